/* design/sha256c_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sha256c_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned HashWords  = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  localparam logic [31:0] INIT_HASH [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Controller to datapath commands
  typedef struct packed {
    logic       shift_in;   // push accepted word into the schedule window
    logic       init_hash;  // reload the standard initial hash
    logic       start;      // copy chained hash into working variables
    logic       round;      // run one compression round
    logic [5:0] round_idx;  // round number for the constant lookup
    logic       update;     // fold working variables into chained hash
    logic       emit;       // load the digest into the output buffer
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // digest buffer still draining
  } sts_t;

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

/* design/sha256c_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha256c_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sha256c_pkg::cmd_t   cmd,
  output sha256c_pkg::sts_t        sts,
  input  wire logic [31:0]         word_in,
  output logic [31:0]              out_word,
  output logic [2:0]               out_idx,
  output logic                     out_valid,
  input  wire logic                out_ready
);

  logic [31:0] win   [sha256c_pkg::BlockWords];
  logic [31:0] v     [sha256c_pkg::HashWords];
  logic [31:0] chain [sha256c_pkg::HashWords];
  logic [31:0] obuf  [sha256c_pkg::HashWords];
  logic [3:0]  ocnt;
  logic [2:0]  oidx;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] sum   [sha256c_pkg::HashWords];
  logic        out_take;

  always_comb begin
    t1 = v[7] + sha256c_pkg::big_s1(v[4]) + sha256c_pkg::choose(v[4], v[5], v[6]) +
         win[0] + sha256c_pkg::ROUND_K[cmd.round_idx];
    t2 = sha256c_pkg::big_s0(v[0]) + sha256c_pkg::majority(v[0], v[1], v[2]);
    w_new = win[0] + sha256c_pkg::small_s0(win[1]) + win[9] + sha256c_pkg::small_s1(win[14]);
    for (int i = 0; i < sha256c_pkg::HashWords; i++) begin
      sum[i] = chain[i] + v[i];
    end
  end

  assign out_take  = out_valid && out_ready;
  assign out_valid = (ocnt != 4'd0);
  assign out_word  = obuf[0];
  assign out_idx   = oidx;
  assign sts.out_busy = out_valid;

  // Schedule window: shift in words while loading, expanded words while rounding
  always_ff @(posedge clk) begin
    if (cmd.shift_in || cmd.round) begin
      for (int i = 0; i < sha256c_pkg::BlockWords - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[sha256c_pkg::BlockWords - 1] <= cmd.shift_in ? word_in : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      v <= chain;
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init_hash) begin
      chain <= sha256c_pkg::INIT_HASH;
    end else if (cmd.update) begin
      chain <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      obuf <= sum;
    end else if (out_take) begin
      for (int i = 0; i < sha256c_pkg::HashWords - 1; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 4'd0;
      oidx <= 3'd0;
    end else if (cmd.emit) begin
      ocnt <= 4'(sha256c_pkg::HashWords);
      oidx <= 3'd0;
    end else if (out_take) begin
      ocnt <= ocnt - 4'd1;
      oidx <= oidx + 3'd1;
    end
  end

endmodule

`default_nettype wire

/* design/sha256c_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha256c_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               first_flag,
  input  wire logic               final_flag,
  output sha256c_pkg::cmd_t       cmd,
  input  wire sha256c_pkg::sts_t  sts
);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_ROUND  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [3:0] wcnt;
  logic [5:0] rcnt;
  logic       final_q;
  logic       accept;

  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.shift_in  = accept;
    cmd.init_hash = accept && (wcnt == 4'd0) && first_flag;
    cmd.start     = accept && (wcnt == 4'd15);
    cmd.round     = (state == ST_ROUND);
    cmd.round_idx = rcnt;
    cmd.update    = (state == ST_FINISH) && (!final_q || !sts.out_busy);
    cmd.emit      = cmd.update && final_q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (cmd.start) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (rcnt == 6'd63) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (cmd.update) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      wcnt  <= 4'd0;
      rcnt  <= 6'd0;
      final_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) wcnt <= wcnt + 4'd1;
      if (cmd.start) begin
        rcnt    <= 6'd0;
        final_q <= final_flag;
      end else if (cmd.round) begin
        rcnt <= rcnt + 6'd1;
      end
    end
  end

  a_start_enters_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_ROUND) && (rcnt == 6'd0))
    else $error("block start did not enter rounds at round zero");

  a_last_round_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) && (rcnt == 6'd63) |=> (state == ST_FINISH))
    else $error("round 63 not followed by finish");

  a_emit_only_final: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> final_q && !sts.out_busy)
    else $error("digest emitted for non-final block or over busy buffer");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) || (state == ST_FINISH) |-> !cmd.shift_in)
    else $error("word accepted during compression");

endmodule

`default_nettype wire

/* design/sha256_block_compression_top.sv */
// SHA-256 block compression.
// Input channel s_axis: one 32-bit message word per item in tdata, sixteen items
// per 512-bit block, already padded and in big-endian word order. tuser carries
// the first-block flag (sampled on a block's first word: reload the standard
// initial hash), tlast the final-block flag (sampled on a block's sixteenth word).
// Output channel m_axis: eight items per final block, digest word in tdata,
// word index 0..7 in tuser (0 most significant), tlast on the eighth word.
// Timing: words load at one per cycle while s_axis_tready is high; after the
// sixteenth word the block runs 64 rounds (one round per cycle through the single
// round unit) and then folds into the chained hash; s_axis_tready is low through
// the rounds and the fold, so a new block's words wait until the fold is done.
// The first digest word shows in the cycle after the fold. The digest sits in its
// own buffer, so a stalled receiver does not hold the loading of the next block;
// only the fold of the next final block waits until the buffer has drained.
// Reset: synchronous, active high; chained hash returns to the initial hash,
// counters clear and the output buffer empties.
`timescale 1ns / 1ps
`default_nettype none

module sha256_block_compression_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] message_word
  input  wire logic [0:0]  s_axis_tuser,   // [0] first_block
  input  wire logic        s_axis_tlast,   // final_block
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast    // last_word
);

  sha256c_pkg::cmd_t cmd;
  sha256c_pkg::sts_t sts;

  // Sequence load, rounds and fold
  sha256c_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .first_flag (s_axis_tuser[0]),
    .final_flag (s_axis_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Schedule window, round unit, chained hash and digest buffer
  sha256c_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .word_in   (s_axis_tdata),
    .out_word  (m_axis_tdata),
    .out_idx   (m_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  // Mark the eighth digest word
  assign m_axis_tlast = m_axis_tvalid && (m_axis_tuser == 3'd7);

endmodule

`default_nettype wire

/* sim/tb_sha256_block_compression_top.sv */
`timescale 1ns / 1ps

module tb_sha256_block_compression_top;

  localparam int ClkHalf    = 6;
  localparam int ResetCycles = 9;
  localparam int LongHold   = 400;   // receiver back-pressure stretch, in cycles
  localparam int QuietLimit = 3000;  // cycles with no item moving on either side
  localparam int TailCycles = 100;   // room for a stray result after the last digest

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // How flags are placed on words where the block must ignore them
  typedef enum int {STRAY_NONE, STRAY_SOME, STRAY_ALL} stray_mode_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  // Running SHA-256 chain and the queue of digest words it predicts
  class digest_board;
    logic [31:0]  chain_hash [8];
    logic [31:0]  block_words [16];
    int           word_pos;
    digest_item_t expected_words [$];
    int           mismatches;
    int           checked;
    int           digests;

    function new();
      foreach (chain_hash[i]) chain_hash[i] = SHA_IV[i];
      foreach (block_words[i]) block_words[i] = '0;
      word_pos   = 0;
      mismatches = 0;
      checked    = 0;
      digests    = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function logic [31:0] lower_sigma0(logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function logic [31:0] lower_sigma1(logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function logic [31:0] upper_sigma0(logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function logic [31:0] upper_sigma1(logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function void compress();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int t = 0; t < 16; t++) sched[t] = block_words[t];
      for (int t = 16; t < 64; t++)
        sched[t] = sched[t-16] + lower_sigma0(sched[t-15]) + sched[t-7] +
                   lower_sigma1(sched[t-2]);
      for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + upper_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
             sched[t] + SHA_K[t];
        t2 = upper_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int i = 7; i > 0; i--) v[i] = v[i-1];
        v[4] = v[4] + t1;  // the shift left the old d in v[4]
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
    endfunction

    // Note one accepted message word; queue the digest after a final block
    function void note_word(logic [31:0] w, logic first_flag, logic final_flag);
      digest_item_t item;
      if (word_pos == 0 && first_flag)
        foreach (chain_hash[i]) chain_hash[i] = SHA_IV[i];
      block_words[word_pos] = w;
      if (word_pos != 15) begin
        word_pos++;
        return;
      end
      word_pos = 0;
      compress();
      if (!final_flag) return;
      digests++;
      for (int i = 0; i < 8; i++) begin
        item.word  = chain_hash[i];
        item.index = 3'(i);
        item.last  = (i == 7);
        expected_words.push_back(item);
      end
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Compare one accepted digest word with the oldest expectation
    function void check_word(logic [31:0] data, logic [2:0] index, logic last);
      digest_item_t want;
      checked++;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected digest word %h index %0d last %b",
                                data, index, last));
        return;
      end
      want = expected_words.pop_front();
      if (data !== want.word || index !== want.index || last !== want.last)
        flag_mismatch($sformatf("digest word %0d: expected %h/%0d/%b, got %h/%0d/%b",
                                checked, want.word, want.index, want.last,
                                data, index, last));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void flag_leftover();
      if (expected_words.size() != 0)
        flag_mismatch($sformatf("%0d digest words never arrived", expected_words.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] message_word
  logic [0:0]  s_axis_tuser;   // [0] first_block
  logic        s_axis_tlast;   // final_block
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] digest_word
  logic [2:0]  m_axis_tuser;   // [2:0] word_index
  logic        m_axis_tlast;   // last_word

  digest_board board;
  int          words_in;
  int          blocks_in;
  int          quiet_cycles = 0;
  bit          calm;
  bit          long_hold_done = 1'b0;

  sha256_block_compression_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(ClkHalf) clk = ~clk;

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and hold the input side quiet; n sets the length of the pause
  task automatic sender_idle(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(input logic [31:0] w, input logic first_flag,
                           input logic final_flag);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= first_flag;
    s_axis_tlast  <= final_flag;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_word(w, first_flag, final_flag);
    words_in++;
  endtask

  // Send sixteen words; flags stand on word 0 / word 15, stray ones elsewhere
  task automatic send_block(input logic [31:0] blk [16], input logic first_flag,
                            input logic final_flag, input stray_mode_t stray,
                            input bit gaps);
    logic f;
    logic l;
    for (int i = 0; i < 16; i++) begin
      if (gaps && !calm && $urandom_range(0, 5) == 0) sender_idle($urandom_range(1, 15));
      f = (i == 0)  ? first_flag :
          (stray == STRAY_ALL) ? 1'b1 : (stray == STRAY_SOME && $urandom_range(0, 2) == 0);
      l = (i == 15) ? final_flag :
          (stray == STRAY_ALL) ? 1'b1 : (stray == STRAY_SOME && $urandom_range(0, 2) == 0);
      send_word(blk[i], f, l);
    end
    blocks_in++;
  endtask

  // Receiver: one long back-pressure stretch, random stall bursts, then steady
  initial begin : receiver
    int  hold_left;
    bit  bursts_on;
    hold_left = 0;
    bursts_on = 1'b1;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) bursts_on = !bursts_on;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && words_in >= 40) begin
        long_hold_done = 1'b1;
        hold_left = LongHold - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && bursts_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Check every digest word taken by the receiver
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no item moved for %0d cycles", QuietLimit);
      $display("tb_sha256_block_compression_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] blk [16];
    int          n_blocks;
    int          rand_words;
    int          rand_digests;
    logic        first_flag;
    logic        final_flag;
    bit          paused;
    board          = new();
    words_in       = 0;
    blocks_in      = 0;
    calm           = 1'b0;
    rand_words     = 0;
    rand_digests   = 0;
    paused         = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // "abc" padded to one block, with both flags raised on every word
    foreach (blk[i]) blk[i] = 32'h0;
    blk[0]  = 32'h6162_6380;
    blk[15] = 32'h0000_0018;
    send_block(blk, 1'b1, 1'b1, STRAY_ALL, 1'b0);
    // all-ones block chained on the previous digest, no reload
    foreach (blk[i]) blk[i] = 32'hffff_ffff;
    send_block(blk, 1'b0, 1'b1, STRAY_NONE, 1'b0);

    // Random messages of one to three blocks; some skip the reload, some
    // never close and run on into the next message
    while (rand_words < 112) begin
      n_blocks = $urandom_range(1, 3);
      for (int b = 0; b < n_blocks; b++) begin
        foreach (blk[i]) blk[i] = pick_word();
        first_flag = (b == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
        final_flag = (b == n_blocks - 1) ? ($urandom_range(0, 7) != 0) : 1'b0;
        send_block(blk, first_flag, final_flag,
                   ($urandom_range(0, 3) == 0) ? STRAY_SOME : STRAY_NONE,
                   $urandom_range(0, 2) != 0);
        rand_words += 16;
        if (final_flag) rand_digests++;
        if (rand_words >= 80) calm = 1'b1;
      end
      // once: let every expected digest drain before offering more words
      if (!paused && final_flag && rand_digests >= 1) begin
        paused = 1'b1;
        sender_idle(1);
        while (board.pending() != 0) @(posedge clk);
      end
    end

    sender_idle(1);
    while (board.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    board.flag_leftover();

    $display("sent %0d message words in %0d blocks; %0d digests, %0d digest words checked",
             words_in, blocks_in, board.digests, board.checked);
    $display("included stray flags, chained messages, a %0d-cycle receiver stall and a drain",
             LongHold);
    if (board.mismatches == 0) begin
      $display("tb_sha256_block_compression_top: clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("tb_sha256_block_compression_top: errors");
    end
    $finish;
  end

endmodule
